/* sv/iml_pkg.sv */
// ============================================================================
// iml_pkg
// Shared types and constants for the periodic Ising lattice with Metropolis
// updates: operation codes, register indexes, field widths, result and
// measure-stream structs.
// ============================================================================
package iml_pkg;

  // Field widths
  localparam int OP_W       = 2;
  localparam int COORD_W    = 8;
  localparam int PROB_W     = 16;
  localparam int SIDE_W     = 9;
  localparam int ENERGY_W   = 19;
  localparam int SUM_W      = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MEASURE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROB4 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROB8 = 2'd2;

  // Register reset values
  localparam logic [SIDE_W-1:0] SIDE_RST  = 9'd16;
  localparam logic [PROB_W-1:0] PROB4_RST = 16'd20545;
  localparam logic [PROB_W-1:0] PROB8_RST = 16'd6441;

  // Per-item result flags held by the sequencer
  typedef struct packed {
    logic status;
    logic accepted;
    logic spin_now;
    logic meas;
  } res_t;

  // One site of the measure walk, aligned with the lattice read data
  typedef struct packed {
    logic clear;     // restart accumulators
    logic vld;
    logic spin;
    logic col0;      // first column of a row
    logic col_last;  // last column of a row
    logic row0;      // first row of the lattice
    logic closing;   // re-read of row 0 for the wrap-around down bonds
  } sweep_t;

  // Energy contribution of one bond: -(a*b)
  function automatic logic signed [2:0] bond_delta(input logic a, input logic b);
    return (a == b) ? -3'sd1 : 3'sd1;
  endfunction

endpackage

/* sv/ising_metropolis_lattice.sv */
// ============================================================================
// ising_metropolis_lattice
// Periodic square Ising lattice: site load, single-site Metropolis redraw
// update and whole-lattice measure of bond energy and spin sum.
// ============================================================================
// Spins live in a MAX_SIDE x MAX_SIDE single-port memory (one bit per site,
// registered read), site (x, y) at y*MAX_SIDE + x. The block works one item
// at a time; a finished result sits in the output register so the next item
// can be taken while it waits. Every site must be loaded before an update or
// measure reads it; unwritten sites read as arbitrary spins. Steps per item,
// set by the single memory port:
//   load: one write, then the result hand-off
//   out-of-range coordinate, unused operation: the result hand-off alone
//   update: five reads (site and four wrapped neighbors), then one
//           decide-and-write step
//   measure: one read per site, then row 0 read again to close the
//           wrap-around down bonds against a one-row buffer
// The effective side is lattice_side clamped to 2..MAX_SIDE. An update keeps
// the proposed spin when the energy change is not positive, or when
// uniform_draw is strictly below accept_prob_four / accept_prob_eight for a
// rise of four / eight. Coordinates at or beyond the side set status and
// change nothing. Configuration is to be written by the user only while the
// block is idle; the block itself does not enforce this.
// ============================================================================
module ising_metropolis_lattice #(
  parameter int MAX_SIDE = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [iml_pkg::OP_W-1:0]            in_operation,
  input  logic [iml_pkg::COORD_W-1:0]         in_site_x,
  input  logic [iml_pkg::COORD_W-1:0]         in_site_y,
  input  logic                                in_spin_bit,
  input  logic [iml_pkg::PROB_W-1:0]          in_uniform_draw,
  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_status,
  output logic                                out_accepted,
  output logic                                out_spin_now,
  output logic signed [iml_pkg::ENERGY_W-1:0] out_energy_total,
  output logic signed [iml_pkg::SUM_W-1:0]    out_spin_sum,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [iml_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [iml_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import iml_pkg::*;

  localparam int CW = $clog2(MAX_SIDE);
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int EW = (SW > SIDE_W) ? SW : SIDE_W;

  // configuration registers
  logic [SIDE_W-1:0] side_r;
  logic [PROB_W-1:0] prob4_r;
  logic [PROB_W-1:0] prob8_r;

  logic [EW-1:0]     side_wide;
  logic [SW-1:0]     side_eff;

  logic              slot_free;
  logic              eng_done;
  res_t              eng_res;
  sweep_t            sweep;
  logic [CW-1:0]     sweep_col;
  logic signed [ENERGY_W-1:0] meas_energy;
  logic signed [SUM_W-1:0]    meas_sum;

  // output register
  logic                       out_valid_r;
  logic                       out_status_r;
  logic                       out_accepted_r;
  logic                       out_spin_now_r;
  logic signed [ENERGY_W-1:0] out_energy_r;
  logic signed [SUM_W-1:0]    out_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r  <= SIDE_RST;
      prob4_r <= PROB4_RST;
      prob8_r <= PROB8_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SIDE:  side_r  <= cfg_wdata[SIDE_W-1:0];
        CFG_PROB4: prob4_r <= cfg_wdata[PROB_W-1:0];
        CFG_PROB8: prob8_r <= cfg_wdata[PROB_W-1:0];
        default:   ;
      endcase
    end
  end

  // clamp the side into 2..MAX_SIDE; the register keeps what was written
  always_comb begin
    side_wide = EW'(side_r);
    if (side_wide < EW'(2)) begin
      side_eff = SW'(2);
    end else if (side_wide > EW'(MAX_SIDE)) begin
      side_eff = SW'(MAX_SIDE);
    end else begin
      side_eff = SW'(side_wide);
    end
  end

  assign slot_free = !out_valid_r || out_ready;

  iml_engine #(
    .MAX_SIDE (MAX_SIDE)
  ) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_site_x       (in_site_x),
    .in_site_y       (in_site_y),
    .in_spin_bit     (in_spin_bit),
    .in_uniform_draw (in_uniform_draw),
    .side_eff        (side_eff),
    .prob_four       (prob4_r),
    .prob_eight      (prob8_r),
    .slot_free       (slot_free),
    .done            (eng_done),
    .res             (eng_res),
    .sweep           (sweep),
    .sweep_col       (sweep_col)
  );

  iml_sweep #(
    .MAX_SIDE (MAX_SIDE)
  ) u_sweep (
    .clk          (clk),
    .rst_n        (rst_n),
    .sweep        (sweep),
    .sweep_col    (sweep_col),
    .energy_total (meas_energy),
    .spin_sum     (meas_sum)
  );

  // result slot: filled by the engine, drained by the consumer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_done) begin
      out_status_r   <= eng_res.status;
      out_accepted_r <= eng_res.accepted;
      out_spin_now_r <= eng_res.spin_now;
      out_energy_r   <= eng_res.meas ? meas_energy : '0;
      out_sum_r      <= eng_res.meas ? meas_sum : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_accepted     = out_accepted_r;
  assign out_spin_now     = out_spin_now_r;
  assign out_energy_total = out_energy_r;
  assign out_spin_sum     = out_sum_r;

  // engine hands over a result only into a free slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    eng_done |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending item");

  // out-of-range items carry nothing but the status flag
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |->
      (!out_accepted && !out_spin_now && out_energy_total == '0 && out_spin_sum == '0))
    else $error("status item with non-zero fields");

  // measure totals never come with site fields
  a_measure_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_energy_total != '0 || out_spin_sum != '0)) |->
      (!out_status && !out_accepted && !out_spin_now))
    else $error("measure item with site fields set");

endmodule

/* sv/iml_sweep.sv */
// ============================================================================
// iml_sweep
// Measure accumulator. Takes the lattice in row-major order, one site per
// cycle, and sums spins and right/down bond energies using a one-row buffer.
// ============================================================================
module iml_sweep #(
  parameter int MAX_SIDE = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  iml_pkg::sweep_t                     sweep,
  input  logic [$clog2(MAX_SIDE)-1:0]         sweep_col,
  output logic signed [iml_pkg::ENERGY_W-1:0] energy_total,
  output logic signed [iml_pkg::SUM_W-1:0]    spin_sum
);
  import iml_pkg::*;

  localparam int CW = $clog2(MAX_SIDE);

  // previous row, one bit per column
  logic          row_mem [MAX_SIDE];
  logic          above_r;
  sweep_t        a_r;
  logic [CW-1:0] acol_r;
  logic          prev_r;
  logic          first_r;

  logic signed [ENERGY_W-1:0] energy_r, energy_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic signed [2:0]          d_right, d_wrap, d_down, delta;

  always_ff @(posedge clk) begin
    if (a_r.vld && !a_r.closing) begin
      row_mem[acol_r] <= a_r.spin;
    end
    above_r <= row_mem[sweep_col];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
    end else begin
      a_r <= sweep;
    end
  end

  always_ff @(posedge clk) begin
    acol_r <= sweep_col;
    if (a_r.vld && !a_r.closing) begin
      prev_r <= a_r.spin;
      if (a_r.col0) begin
        first_r <= a_r.spin;
      end
    end
  end

  always_comb begin
    d_right = '0;
    d_wrap  = '0;
    d_down  = '0;
    if (!a_r.closing) begin
      if (!a_r.col0) begin
        d_right = bond_delta(prev_r, a_r.spin);
      end
      if (a_r.col_last) begin
        d_wrap = bond_delta(a_r.spin, first_r);
      end
    end
    // closing pass pairs the last row (in the buffer) with row 0
    if (a_r.closing || !a_r.row0) begin
      d_down = bond_delta(above_r, a_r.spin);
    end
    delta      = d_right + d_wrap + d_down;
    energy_nxt = energy_r + {{(ENERGY_W-3){delta[2]}}, delta};
    sum_nxt    = a_r.spin ? sum_r + SUM_W'(1) : sum_r - SUM_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r <= '0;
      sum_r    <= '0;
    end else if (sweep.clear) begin
      energy_r <= '0;
      sum_r    <= '0;
    end else if (a_r.vld) begin
      energy_r <= energy_nxt;
      if (!a_r.closing) begin
        sum_r <= sum_nxt;
      end
    end
  end

  assign energy_total = energy_r;
  assign spin_sum     = sum_r;

endmodule

/* sv/iml_engine.sv */
// ============================================================================
// iml_engine
// Sequencer and lattice memory. Runs load, Metropolis update and the
// measure walk against a single-port spin memory with registered read.
// ============================================================================
module iml_engine #(
  parameter int MAX_SIDE = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [iml_pkg::OP_W-1:0]             in_operation,
  input  logic [iml_pkg::COORD_W-1:0]          in_site_x,
  input  logic [iml_pkg::COORD_W-1:0]          in_site_y,
  input  logic                                 in_spin_bit,
  input  logic [iml_pkg::PROB_W-1:0]           in_uniform_draw,
  input  logic [$clog2(MAX_SIDE+1)-1:0]        side_eff,
  input  logic [iml_pkg::PROB_W-1:0]           prob_four,
  input  logic [iml_pkg::PROB_W-1:0]           prob_eight,
  input  logic                                 slot_free,
  output logic                                 done,
  output iml_pkg::res_t                        res,
  output iml_pkg::sweep_t                      sweep,
  output logic [$clog2(MAX_SIDE)-1:0]          sweep_col
);
  import iml_pkg::*;

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_SIDE);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int KW    = (SW > COORD_W) ? SW : COORD_W;

  // read slots of an update
  localparam logic [2:0] RD_CENTER = 3'd0;
  localparam logic [2:0] RD_RIGHT  = 3'd1;
  localparam logic [2:0] RD_LEFT   = 3'd2;
  localparam logic [2:0] RD_DOWN   = 3'd3;
  localparam logic [2:0] RD_UP     = 3'd4;
  localparam logic [2:0] DRAIN_END = 3'd1;

  // neighbors equal to the old spin: 3 means a rise of 4, 4 a rise of 8
  localparam logic [2:0] K_RISE4 = 3'd3;
  localparam logic [2:0] K_RISE8 = 3'd4;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_DEC   = 7'b0001000,
    S_MEAS  = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  function automatic logic [AW-1:0] site_addr(input logic [CW-1:0] sx,
                                              input logic [CW-1:0] sy);
    return AW'(sy) * AW'(MAX_SIDE) + AW'(sx);
  endfunction

  state_t st_r, st_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]     x_r, x_nxt, y_r, y_nxt;
  logic              bit_r, bit_nxt;
  logic [PROB_W-1:0] draw_r, draw_nxt;
  logic              old_r, old_nxt;
  logic [2:0]        k_r, k_nxt;
  logic [CW-1:0]     cx_r, cx_nxt, cy_r, cy_nxt;
  logic              closing_r, closing_nxt;
  res_t              res_r, res_nxt;
  sweep_t            mp_r, mp_nxt;
  logic [CW-1:0]     mcol_r, mcol_nxt;

  logic              lat_mem [DEPTH];
  logic              lat_rd_r;
  logic              mem_we, mem_wd;
  logic [AW-1:0]     mem_addr;

  logic              take, off, is_site, bad, acc;
  logic [2:0]        k_fin;
  logic [CW-1:0]     side_m1, xr, xl, yd, yu;

  // single-port lattice memory, read-first
  always_ff @(posedge clk) begin
    if (mem_we) begin
      lat_mem[mem_addr] <= mem_wd;
    end
    lat_rd_r <= lat_mem[mem_addr];
  end

  assign side_m1  = CW'(side_eff - SW'(1));
  assign xr       = (x_r == side_m1) ? '0 : x_r + CW'(1);
  assign xl       = (x_r == '0) ? side_m1 : x_r - CW'(1);
  assign yd       = (y_r == side_m1) ? '0 : y_r + CW'(1);
  assign yu       = (y_r == '0) ? side_m1 : y_r - CW'(1);

  assign in_ready = (st_r == S_IDLE) || ((st_r == S_RESP) && slot_free);
  assign take     = in_valid && in_ready;
  assign done     = (st_r == S_RESP) && slot_free;

  assign off     = (KW'(in_site_x) >= KW'(side_eff)) || (KW'(in_site_y) >= KW'(side_eff));
  assign is_site = (in_operation == OP_LOAD) || (in_operation == OP_UPDATE);
  assign bad     = is_site && off;

  // Metropolis decision; last neighbor arrives in the decide cycle
  always_comb begin
    k_fin = k_r + {2'b00, lat_rd_r == old_r};
    if (bit_r == old_r) begin
      acc = 1'b1;
    end else if (k_fin == K_RISE8) begin
      acc = draw_r < prob_eight;
    end else if (k_fin == K_RISE4) begin
      acc = draw_r < prob_four;
    end else begin
      acc = 1'b1;
    end
  end

  always_comb begin
    st_nxt      = st_r;
    cnt_nxt     = cnt_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    bit_nxt     = bit_r;
    draw_nxt    = draw_r;
    old_nxt     = old_r;
    k_nxt       = k_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    closing_nxt = closing_r;
    res_nxt     = res_r;
    mp_nxt      = '0;
    mcol_nxt    = cx_r;
    mem_we      = 1'b0;
    mem_wd      = bit_r;
    mem_addr    = site_addr(x_r, y_r);

    case (st_r)
      S_IDLE, S_RESP: begin
        if (take) begin
          x_nxt       = CW'(in_site_x);
          y_nxt       = CW'(in_site_y);
          bit_nxt     = in_spin_bit;
          draw_nxt    = in_uniform_draw;
          cnt_nxt     = '0;
          k_nxt       = '0;
          cx_nxt      = '0;
          cy_nxt      = '0;
          closing_nxt = 1'b0;
          res_nxt     = '0;
          res_nxt.status = bad;
          if (bad) begin
            st_nxt = S_RESP;
          end else begin
            case (in_operation)
              OP_LOAD:   st_nxt = S_LOAD;
              OP_UPDATE: st_nxt = S_RD;
              OP_MEASURE: begin
                st_nxt       = S_MEAS;
                res_nxt.meas = 1'b1;
                mp_nxt.clear = 1'b1;
              end
              default:   st_nxt = S_RESP;
            endcase
          end
        end else if (st_r == S_RESP && slot_free) begin
          st_nxt = S_IDLE;
        end
      end

      S_LOAD: begin
        mem_we           = 1'b1;
        res_nxt.spin_now = bit_r;
        st_nxt           = S_RESP;
      end

      S_RD: begin
        case (cnt_r)
          RD_CENTER: mem_addr = site_addr(x_r, y_r);
          RD_RIGHT:  mem_addr = site_addr(xr, y_r);
          RD_LEFT:   mem_addr = site_addr(xl, y_r);
          RD_DOWN:   mem_addr = site_addr(x_r, yd);
          RD_UP:     mem_addr = site_addr(x_r, yu);
          default:   mem_addr = site_addr(x_r, y_r);
        endcase
        // read data belongs to the address of the previous slot
        if (cnt_r == RD_RIGHT) begin
          old_nxt = lat_rd_r;
        end else if (cnt_r != RD_CENTER) begin
          k_nxt = k_r + {2'b00, lat_rd_r == old_r};
        end
        if (cnt_r == RD_UP) begin
          st_nxt  = S_DEC;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end

      S_DEC: begin
        mem_we           = acc;
        res_nxt.accepted = acc;
        res_nxt.spin_now = acc ? bit_r : old_r;
        st_nxt           = S_RESP;
      end

      S_MEAS: begin
        mem_addr        = site_addr(cx_r, cy_r);
        mp_nxt.vld      = 1'b1;
        mp_nxt.col0     = (cx_r == '0);
        mp_nxt.col_last = (cx_r == side_m1);
        mp_nxt.row0     = (cy_r == '0);
        mp_nxt.closing  = closing_r;
        if (cx_r == side_m1) begin
          cx_nxt = '0;
          if (closing_r) begin
            st_nxt  = S_DRAIN;
            cnt_nxt = '0;
          end else if (cy_r == side_m1) begin
            cy_nxt      = '0;
            closing_nxt = 1'b1;
          end else begin
            cy_nxt = cy_r + CW'(1);
          end
        end else begin
          cx_nxt = cx_r + CW'(1);
        end
      end

      S_DRAIN: begin
        // read latency plus accumulator stage
        if (cnt_r == DRAIN_END) begin
          st_nxt = S_RESP;
        end
        cnt_nxt = cnt_r + 3'd1;
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      cnt_r     <= '0;
      closing_r <= 1'b0;
      mp_r      <= '0;
    end else begin
      st_r      <= st_nxt;
      cnt_r     <= cnt_nxt;
      closing_r <= closing_nxt;
      mp_r      <= mp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    bit_r  <= bit_nxt;
    draw_r <= draw_nxt;
    old_r  <= old_nxt;
    k_r    <= k_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    res_r  <= res_nxt;
    mcol_r <= mcol_nxt;
  end

  always_comb begin
    sweep      = mp_r;
    sweep.spin = lat_rd_r;
  end

  assign sweep_col = mcol_r;
  assign res       = res_r;

endmodule

/* tb/tb_top.sv */
// ============================================================================
// tb_top
// Self-checking bench for the periodic Ising lattice with Metropolis updates.
// Items go in over a valid/ready channel. A predictor keeps its own copy of
// the spins and registers and works out the result of each accepted item.
// Results are compared field by field in order. Directed tests cover reset
// values, side clamping, threshold edges and the largest lattice. Random
// phases then mix loads, updates, measures and bad coordinates with random
// idling on both sides.
// ============================================================================
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import iml_pkg::*;

  localparam int LAT_MAX = 256;
  // Operation code with no function: the block must answer with all zeros.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [COORD_W-1:0] site_x;
    logic [COORD_W-1:0] site_y;
    logic               spin_bit;
    logic [PROB_W-1:0]  uniform_draw;
  } site_cmd_t;

  typedef struct packed {
    logic                       status;
    logic                       accepted;
    logic                       spin_now;
    logic signed [ENERGY_W-1:0] energy_total;
    logic signed [SUM_W-1:0]    spin_sum;
  } lattice_res_t;

  // --------------------------------------------------------------------------
  // DUT ports; the inputs are all driven to known values from time zero
  // --------------------------------------------------------------------------
  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [OP_W-1:0]            in_operation = '0;
  logic [COORD_W-1:0]         in_site_x = '0;
  logic [COORD_W-1:0]         in_site_y = '0;
  logic                       in_spin_bit = 1'b0;
  logic [PROB_W-1:0]          in_uniform_draw = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_status;
  logic                       out_accepted;
  logic                       out_spin_now;
  logic signed [ENERGY_W-1:0] out_energy_total;
  logic signed [SUM_W-1:0]    out_spin_sum;
  logic                       cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

  always #5 clk = ~clk;

  ising_metropolis_lattice i_dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_operation,
    .in_site_x,
    .in_site_y,
    .in_spin_bit,
    .in_uniform_draw,
    .out_valid,
    .out_ready,
    .out_status,
    .out_accepted,
    .out_spin_now,
    .out_energy_total,
    .out_spin_sum,
    .cfg_wr_en,
    .cfg_index,
    .cfg_wdata
  );

  // --------------------------------------------------------------------------
  // Predictor state: spins, which sites were ever written, and registers.
  // Site (x, y) sits at y*LAT_MAX + x, same as in the block.
  // --------------------------------------------------------------------------
  bit                 lat_spin [LAT_MAX*LAT_MAX];
  bit                 lat_written [LAT_MAX*LAT_MAX];
  logic [SIDE_W-1:0]  side_reg;
  logic [PROB_W-1:0]  prob4_reg;
  logic [PROB_W-1:0]  prob8_reg;

  lattice_res_t       result_q [$];   // results still owed by the block, oldest first
  int unsigned        items_sent = 0;
  int unsigned        mismatch_count = 0;
  int unsigned        gap_max = 9;     // sender idle cycles per item, upper bound
  int unsigned        stall_max = 9;   // receiver stall cycles per item, upper bound

  // Side in use: register clamped to 2..LAT_MAX.
  function automatic int side_eff();
    if (side_reg < 2) return 2;
    if (side_reg > LAT_MAX) return LAT_MAX;
    return int'(side_reg);
  endfunction

  function automatic int spin_val(int x, int y);
    return lat_spin[y*LAT_MAX + x] ? 1 : -1;
  endfunction

  // Works out the result of one item and applies its effect on the lattice.
  function automatic lattice_res_t predict_item(site_cmd_t c);
    lattice_res_t r;
    int s, idx, nsum, old_s, new_s, de, energy, total;
    bit keep;
    r = '0;
    s = side_eff();
    idx = int'(c.site_y) * LAT_MAX + int'(c.site_x);
    if (c.operation == OP_LOAD || c.operation == OP_UPDATE) begin
      if (c.site_x >= s || c.site_y >= s) begin
        r.status = 1'b1;
        return r;
      end
      if (c.operation == OP_LOAD) begin
        lat_spin[idx] = c.spin_bit;
        lat_written[idx] = 1'b1;
        r.spin_now = c.spin_bit;
      end else begin
        // four wrapped neighbors on the torus
        nsum = spin_val((c.site_x + 1) % s, c.site_y)
             + spin_val((c.site_x + s - 1) % s, c.site_y)
             + spin_val(c.site_x, (c.site_y + 1) % s)
             + spin_val(c.site_x, (c.site_y + s - 1) % s);
        old_s = spin_val(c.site_x, c.site_y);
        new_s = c.spin_bit ? 1 : -1;
        de = -(new_s - old_s) * nsum;
        if (de <= 0) keep = 1'b1;
        else if (de == 4) keep = (c.uniform_draw < prob4_reg);
        else keep = (c.uniform_draw < prob8_reg);
        if (keep) lat_spin[idx] = c.spin_bit;
        r.accepted = keep;
        r.spin_now = lat_spin[idx];
      end
    end else if (c.operation == OP_MEASURE) begin
      energy = 0;
      total = 0;
      for (int y = 0; y < s; y++) begin
        for (int x = 0; x < s; x++) begin
          energy -= spin_val(x, y) * (spin_val((x + 1) % s, y) + spin_val(x, (y + 1) % s));
          total += spin_val(x, y);
        end
      end
      r.energy_total = energy[ENERGY_W-1:0];
      r.spin_sum = total[SUM_W-1:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Drives one item after a random idle gap; valid stays up across
  // back-to-back items. The expectation is queued at the accepting edge.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic spin,
                           input logic [PROB_W-1:0] draw);
    site_cmd_t   cmd;
    int unsigned gap;
    cmd = '{op, x, y, spin, draw};
    gap = $urandom_range(0, gap_max);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid        = 1'b1;
    in_operation    = op;
    in_site_x       = x;
    in_site_y       = y;
    in_spin_bit     = spin;
    in_uniform_draw = draw;
    do @(posedge clk); while (in_ready !== 1'b1);
    result_q.push_back(predict_item(cmd));
    items_sent++;
  endtask

  // Stop sending and wait for every owed result.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // Register write, only with the block idle. Predictor copy keeps the
  // register width, so wide data gets masked the same way.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      CFG_SIDE:  side_reg  = value[SIDE_W-1:0];
      CFG_PROB4: prob4_reg = value;
      CFG_PROB8: prob8_reg = value;
      default: ;
    endcase
  endtask

  // Loads every not-yet-written site of the side in use, so that no update
  // or measure ever reads an undefined spin.
  task automatic fill_lattice();
    int s;
    s = side_eff();
    for (int y = 0; y < s; y++) begin
      for (int x = 0; x < s; x++) begin
        if (!lat_written[y*LAT_MAX + x])
          send_item(OP_LOAD, COORD_W'(x), COORD_W'(y), 1'($urandom_range(0, 1)),
                    PROB_W'($urandom));
      end
    end
  endtask

  // Draw that lands on, just under or just over a threshold, at an end of
  // the range, or anywhere.
  function automatic logic [PROB_W-1:0] pick_draw();
    int v;
    case ($urandom_range(0, 3))
      0:       v = int'(prob4_reg) + int'($urandom_range(0, 2)) - 1;
      1:       v = int'(prob8_reg) + int'($urandom_range(0, 2)) - 1;
      2:       v = $urandom_range(0, 1) ? 65535 : 0;
      default: v = $urandom_range(0, 65535);
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[PROB_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Receiver side: random stall per item, then compare against the oldest
  // expectation.
  // --------------------------------------------------------------------------
  task automatic check_result();
    lattice_res_t want;
    if (result_q.size() == 0) begin
      $error("result item with nothing expected");
      mismatch_count++;
      return;
    end
    want = result_q.pop_front();
    if (out_status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, out_status);
      mismatch_count++;
    end
    if (out_accepted !== want.accepted) begin
      $error("accepted: expected %0d, got %0d", want.accepted, out_accepted);
      mismatch_count++;
    end
    if (out_spin_now !== want.spin_now) begin
      $error("spin_now: expected %0d, got %0d", want.spin_now, out_spin_now);
      mismatch_count++;
    end
    if (out_energy_total !== want.energy_total) begin
      $error("energy_total: expected %0d, got %0d", want.energy_total, out_energy_total);
      mismatch_count++;
    end
    if (out_spin_sum !== want.spin_sum) begin
      $error("spin_sum: expected %0d, got %0d", want.spin_sum, out_spin_sum);
      mismatch_count++;
    end
  endtask

  always begin : result_sink
    int unsigned stall;
    stall = $urandom_range(0, stall_max);
    repeat (stall) begin
      @(negedge clk);
      out_ready = 1'b0;
    end
    @(negedge clk);
    out_ready = 1'b1;
    do @(posedge clk); while (out_valid !== 1'b1);
    check_result();
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset values: side 16 and the default thresholds. A cross of five sites
  // around (5,5) is set up so each energy change can be forced.
  task automatic test_reset_values();
    send_item(OP_LOAD, 8'd5, 8'd5, 1'b1, 16'd0);
    send_item(OP_LOAD, 8'd6, 8'd5, 1'b1, 16'd0);
    send_item(OP_LOAD, 8'd4, 8'd5, 1'b1, 16'd0);
    send_item(OP_LOAD, 8'd5, 8'd6, 1'b1, 16'd0);
    send_item(OP_LOAD, 8'd5, 8'd4, 1'b1, 16'd0);
    // rise of eight: draw equal to threshold is refused, one below is kept
    send_item(OP_UPDATE, 8'd5, 8'd5, 1'b0, PROB8_RST);
    send_item(OP_UPDATE, 8'd5, 8'd5, 1'b0, PROB8_RST - 16'd1);
    // drop of eight, kept even with the largest draw
    send_item(OP_UPDATE, 8'd5, 8'd5, 1'b1, 16'hFFFF);
    // one neighbor down: rise and drop of four
    send_item(OP_LOAD, 8'd5, 8'd4, 1'b0, 16'hFFFF);
    send_item(OP_UPDATE, 8'd5, 8'd5, 1'b0, PROB4_RST);
    send_item(OP_UPDATE, 8'd5, 8'd5, 1'b0, PROB4_RST - 16'd1);
    send_item(OP_UPDATE, 8'd5, 8'd5, 1'b0, 16'd0);       // redraw of same spin
    send_item(OP_UPDATE, 8'd5, 8'd5, 1'b1, 16'hFFFF);
    // neighbors cancel: zero change, always kept
    send_item(OP_LOAD, 8'd6, 8'd5, 1'b0, 16'd0);
    send_item(OP_UPDATE, 8'd5, 8'd5, 1'b0, 16'hFFFF);
    // last in-range site, then coordinates at and past the side
    send_item(OP_LOAD, 8'd15, 8'd15, 1'b1, 16'd0);
    send_item(OP_LOAD, 8'd16, 8'd0, 1'b1, 16'd0);
    send_item(OP_UPDATE, 8'd0, 8'd16, 1'b1, 16'd0);
    send_item(OP_LOAD, 8'd255, 8'd255, 1'b1, 16'hFFFF);
    send_item(OP_UPDATE, 8'd255, 8'd0, 1'b0, 16'hFFFF);
    send_item(OP_UNUSED, 8'd255, 8'd255, 1'b1, 16'hFFFF);
  endtask

  // Side below two acts as two; measure and wrap on the smallest torus.
  task automatic test_side_clamp_low();
    write_reg(CFG_SIDE, 16'd0);
    fill_lattice();
    send_item(OP_MEASURE, 8'd0, 8'd0, 1'b0, 16'd0);
    send_item(OP_UPDATE, 8'd1, 8'd1, 1'b1, 16'd0);
    send_item(OP_UPDATE, 8'd0, 8'd0, 1'b0, 16'hFFFF);
    send_item(OP_LOAD, 8'd2, 8'd0, 1'b1, 16'd0);
    send_item(OP_UPDATE, 8'd0, 8'd2, 1'b1, 16'd0);
    send_item(OP_MEASURE, 8'd255, 8'd255, 1'b1, 16'hFFFF);
    write_reg(CFG_SIDE, 16'd1);
    send_item(OP_UPDATE, 8'd1, 8'd0, 1'b0, 16'd0);
    send_item(OP_MEASURE, 8'd7, 8'd3, 1'b0, 16'd0);
    write_reg(CFG_SIDE, 16'd2);
    send_item(OP_MEASURE, 8'd0, 8'd0, 1'b0, 16'd0);
  endtask

  // Threshold extremes: zero refuses every rise, all ones keeps every rise
  // except the largest draw.
  task automatic test_threshold_extremes();
    write_reg(CFG_SIDE, 16'd3);
    fill_lattice();
    for (int k = 0; k < 2; k++) begin
      write_reg(CFG_PROB4, k ? 16'hFFFF : 16'h0000);
      write_reg(CFG_PROB8, k ? 16'hFFFF : 16'h0000);
      repeat (12)
        send_item(OP_UPDATE, COORD_W'($urandom_range(0, 2)), COORD_W'($urandom_range(0, 2)),
                  1'($urandom_range(0, 1)), pick_draw());
      send_item(OP_MEASURE, 8'd0, 8'd0, 1'b0, 16'd0);
    end
  endtask

  // Random phases: new registers, fill, then a mix dominated by in-range
  // updates. Out-of-range and unused-op items are the noise.
  task automatic test_random_phases();
    int unsigned start, pick, n;
    int          s;
    logic [COORD_W-1:0] x, y;
    start = items_sent;
    while (items_sent - start < 1000) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: write_reg(CFG_SIDE, CFG_DATA_W'($urandom_range(2, 8)));
        7, 8:                write_reg(CFG_SIDE, CFG_DATA_W'($urandom_range(9, 16)));
        default:             write_reg(CFG_SIDE, CFG_DATA_W'($urandom_range(0, 1)));
      endcase
      for (int k = 0; k < 2; k++) begin
        case ($urandom_range(0, 4))
          0:       pick = 0;
          1:       pick = 65535;
          2:       pick = k ? PROB8_RST : PROB4_RST;
          default: pick = $urandom_range(0, 65535);
        endcase
        write_reg(k ? CFG_PROB8 : CFG_PROB4, pick[PROB_W-1:0]);
      end
      s = side_eff();
      fill_lattice();
      n = $urandom_range(40, 100);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        x = COORD_W'($urandom_range(0, s - 1));
        y = COORD_W'($urandom_range(0, s - 1));
        if (pick < 62) begin
          send_item(OP_UPDATE, x, y, 1'($urandom_range(0, 1)), pick_draw());
        end else if (pick < 78) begin
          send_item(OP_LOAD, x, y, 1'($urandom_range(0, 1)), PROB_W'($urandom));
        end else if (pick < 86) begin
          // coordinates mean nothing to a measure
          send_item(OP_MEASURE, COORD_W'($urandom), COORD_W'($urandom),
                    1'($urandom_range(0, 1)), PROB_W'($urandom));
        end else if (pick < 95) begin
          if ($urandom_range(0, 1)) x = COORD_W'($urandom_range(s, 255));
          else y = COORD_W'($urandom_range(s, 255));
          send_item($urandom_range(0, 1) ? OP_LOAD : OP_UPDATE, x, y,
                    1'($urandom_range(0, 1)), PROB_W'($urandom));
        end else begin
          send_item(OP_UNUSED, COORD_W'($urandom), COORD_W'($urandom),
                    1'($urandom_range(0, 1)), PROB_W'($urandom));
        end
        // now and then hold off until the block has answered everything
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
    end
  endtask

  // Largest lattice: the sites within two of each corner (wrapping) are
  // loaded, then updates at the corners wrap across both edges. The side is
  // then written above the maximum with all data bits set, so only the
  // register's low bits count, and the corners must wrap the same way.
  task automatic test_side_max();
    write_reg(CFG_SIDE, CFG_DATA_W'(LAT_MAX));
    for (int y = 0; y < 4; y++)
      for (int x = 0; x < 4; x++)
        send_item(OP_LOAD, COORD_W'(x + LAT_MAX - 2), COORD_W'(y + LAT_MAX - 2),
                  1'($urandom_range(0, 1)), PROB_W'($urandom));
    send_item(OP_UPDATE, 8'd0, 8'd0, 1'b0, 16'd0);
    send_item(OP_UPDATE, 8'd255, 8'd255, 1'b0, 16'hFFFF);
    send_item(OP_LOAD, 8'd255, 8'd0, 1'b0, 16'd0);
    send_item(OP_UPDATE, 8'd0, 8'd255, 1'b0, pick_draw());
    send_item(OP_UPDATE, 8'd255, 8'd0, 1'b1, pick_draw());
    write_reg(CFG_SIDE, 16'hFFFF);
    repeat (8)
      send_item(OP_UPDATE, $urandom_range(0, 1) ? 8'd255 : 8'd0,
                $urandom_range(0, 1) ? 8'd255 : 8'd0,
                1'($urandom_range(0, 1)), pick_draw());
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    side_reg  = SIDE_RST;
    prob4_reg = PROB4_RST;
    prob8_reg = PROB8_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_side_clamp_low();
    test_threshold_extremes();
    test_random_phases();
    test_side_max();

    // everything answered; leave room for any stray result
    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: reports mismatches and stops a run that has not finished on its own.
  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
